@@ rtl/core/gdpf_pkg.sv @@
// ----------------------------------------------------------------------------
// gdpf_pkg
// Shared types and constants for the graduated density pixel filter.
// ----------------------------------------------------------------------------
package gdpf_pkg;

   localparam int CHANNELS   = 4;
   localparam int TINTED     = 3;
   localparam int SAMPLE_W   = 18;
   localparam int COORD_W    = 14;
   localparam int DENSITY_W  = 13;
   localparam int TINT_W     = 16;
   localparam int COLOR_W    = 17;
   localparam int POS_W      = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CLIP_W     = 25;
   localparam int X_W        = 37;
   localparam int T_W        = 31;
   localparam int D_W        = 40;
   localparam int SCALE_W    = 41;
   localparam int DIV_STAGES = SAMPLE_W;

   localparam logic [CLIP_W-1:0]   Q24_ONE    = CLIP_W'(24'd8388608 * 2);
   localparam logic [31:0]         LN2_Q32    = 32'hB17217F8;
   localparam logic [31:0]         THIRD_Q32  = 32'h55555555;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DENSITY    = 3'd0,
      REG_TINT_RED   = 3'd1,
      REG_TINT_GREEN = 3'd2,
      REG_TINT_BLUE  = 3'd3,
      REG_ORIGIN     = 3'd4,
      REG_COL_STEP   = 3'd5,
      REG_ROW_STEP   = 3'd6
   } reg_index_type;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef sample_type [CHANNELS-1:0] pixel_type;

   // CSR settings; user holds static while items are in flight, unenforced.
   typedef struct packed {
      logic                           neg;
      logic                           div_en;
      logic [DENSITY_W-1:0]           mag;
      logic [TINTED-1:0][COLOR_W-1:0] color;
      logic signed [POS_W-1:0]        origin;
      logic signed [POS_W-1:0]        column_step;
      logic signed [POS_W-1:0]        row_step;
   } cfg_type;

   typedef struct packed {
      logic [SCALE_W-1:0] rem;
      logic [SCALE_W-1:0] div;
      sample_type         quo;
   } lane_type;

   typedef lane_type [CHANNELS-1:0] lanes_type;

endpackage

@@ rtl/core/gdpf_position.sv @@
// ----------------------------------------------------------------------------
// gdpf_position
// Gradient position, clip against the half point and exponent x in Q.32.
// Three register stages.
// ----------------------------------------------------------------------------
module gdpf_position import gdpf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  cfg_type            cfg,
   input  logic               in_valid,
   input  logic [COORD_W-1:0] column,
   input  logic [COORD_W-1:0] row,
   input  pixel_type          in_pixel,
   output logic               out_valid,
   output logic [X_W-1:0]     x,
   output pixel_type          out_pixel
);

   localparam logic signed [49:0] HALF_V = 50'sd8388608;
   localparam logic signed [49:0] ONE_V  = 50'sd16777216;

   logic                     v1_ff, v2_ff, v3_ff;
   logic signed [47:0]       prod_col_ff, prod_col_in;
   logic signed [47:0]       prod_row_ff, prod_row_in;
   logic [CLIP_W-1:0]        q_ff, q_in;
   logic [X_W-1:0]           x_ff, x_in;
   pixel_type                pix1_ff, pix2_ff, pix3_ff;
   logic [COORD_W:0]         col_p1;
   logic signed [48:0]       pos;
   logic signed [49:0]       v;

   assign col_p1      = {1'b0, column} + (COORD_W+1)'(1);
   assign prod_col_in = $signed({1'b0, col_p1}) * cfg.column_step;
   assign prod_row_in = $signed({2'b0, row}) * cfg.row_step;

   always_comb begin
      pos = 49'(prod_col_ff) + 49'(prod_row_ff) + 49'(cfg.origin);
      v   = cfg.neg ? HALF_V - 50'(pos) : HALF_V + 50'(pos);
      if (v < 0) begin
         q_in = '0;
      end else if (v > ONE_V) begin
         q_in = Q24_ONE;
      end else begin
         q_in = v[CLIP_W-1:0];
      end
   end

   assign x_in = X_W'(cfg.mag) * X_W'(q_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_col_ff <= prod_col_in;
         prod_row_ff <= prod_row_in;
         pix1_ff     <= in_pixel;
         q_ff        <= q_in;
         pix2_ff     <= pix1_ff;
         x_ff        <= x_in;
         pix3_ff     <= pix2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign x         = x_ff;
   assign out_pixel = pix3_ff;

   assert property (@(posedge clock) disable iff (reset) v2_ff |-> (q_ff <= Q24_ONE))
      else $error("clip factor above one");

endmodule

@@ rtl/core/gdpf_exp2.sv @@
// ----------------------------------------------------------------------------
// gdpf_exp2
// 2^x as a fourth-order series of e^t, t = x*ln2/8, raised to the eighth
// power by three squarings. Nine register stages, at most one multiply each.
// ----------------------------------------------------------------------------
module gdpf_exp2 import gdpf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  logic           in_valid,
   input  logic [X_W-1:0] x,
   input  pixel_type      in_pixel,
   output logic           out_valid,
   output logic [D_W-1:0] dval,
   output pixel_type      out_pixel
);

   localparam int NST = 9;

   logic [NST-1:0]        v_ff;
   pixel_type [NST-1:0]   pix_ff;
   logic [T_W-1:0]        t1_ff, t2_ff, t3_ff, t4_ff;
   logic [T_W-1:0]        d1_2_ff, d1_3_ff, d1_4_ff;
   logic [31:0]           m_ff;
   logic [31:0]           d2_ff;
   logic [T_W-1:0]        d3_ff;
   logic [32:0]           part_ff, e_ff;
   logic [27:0]           p1_ff;
   logic [31:0]           p2_ff;
   logic [D_W-1:0]        d_ff;

   logic [64:0]           prod_t;
   logic [61:0]           prod_d1, prod_m;
   logic [63:0]           prod_d2;
   logic [62:0]           prod_d3;
   logic [25:0]           p;
   logic [51:0]           prod_p1;
   logic [55:0]           prod_p2;
   logic [63:0]           prod_d;

   assign prod_t  = 65'(x[X_W-1:4]) * 65'(LN2_Q32);
   assign prod_d1 = 62'(t1_ff) * 62'(t1_ff);
   assign prod_m  = 62'(d1_2_ff) * 62'(t2_ff);
   assign prod_d2 = 64'(m_ff) * 64'(THIRD_Q32);
   assign prod_d3 = 63'(d2_ff) * 63'(t4_ff);
   // The series value stays below 4.0, so e fits in 32 bits and p in 26.
   assign p       = e_ff[31:6];
   assign prod_p1 = 52'(p) * 52'(p);
   assign prod_p2 = 56'(p1_ff) * 56'(p1_ff);
   assign prod_d  = 64'(p2_ff) * 64'(p2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= {v_ff[NST-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pix_ff  <= {pix_ff[NST-2:0], in_pixel};
         t1_ff   <= prod_t[63:33];
         t2_ff   <= t1_ff;
         d1_2_ff <= prod_d1[61:31];
         t3_ff   <= t2_ff;
         d1_3_ff <= d1_2_ff;
         m_ff    <= prod_m[61:30];
         t4_ff   <= t3_ff;
         d1_4_ff <= d1_3_ff;
         d2_ff   <= prod_d2[63:32];
         d3_ff   <= prod_d3[62:32];
         part_ff <= 33'h040000000 + 33'(t4_ff) + 33'(d1_4_ff) + 33'(d2_ff);
         e_ff    <= part_ff + 33'(d3_ff);
         p1_ff   <= prod_p1[51:24];
         p2_ff   <= prod_p2[55:24];
         d_ff    <= prod_d[63:24];
      end
   end

   assign out_valid = v_ff[NST-1];
   assign dval      = d_ff;
   assign out_pixel = pix_ff[NST-1];

   assert property (@(posedge clock) disable iff (reset)
      v_ff[NST-1] |-> (d_ff >= D_W'(Q24_ONE)))
      else $error("2^x below one");
   assert property (@(posedge clock) disable iff (reset)
      v_ff[5] |-> (e_ff[32] == 1'b0))
      else $error("series value out of range");

endmodule

@@ rtl/core/gdpf_scale.sv @@
// ----------------------------------------------------------------------------
// gdpf_scale
// Per-channel scale s = c + (1-c)*2^x, then the multiply path result or the
// divider start values. Two register stages.
// ----------------------------------------------------------------------------
module gdpf_scale import gdpf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  cfg_type        cfg,
   input  logic           in_valid,
   input  logic [D_W-1:0] dval,
   input  pixel_type      in_pixel,
   output logic           out_valid,
   output lanes_type      lanes
);

   logic                             v1_ff, v2_ff;
   logic [CHANNELS-1:0][SCALE_W-1:0] s_ff, s_in;
   pixel_type                        pix_ff;
   lanes_type                        lanes_ff, lanes_in;
   logic [CHANNELS-1:0][COLOR_W-1:0] color;
   logic [CHANNELS-1:0][56:0]        prod_s;
   logic [CHANNELS-1:0][58:0]        prod_m;

   always_comb begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
         color[ch] = (ch < TINTED) ? cfg.color[ch % TINTED] : '0;
         prod_s[ch] = 57'(COLOR_W'(18'd65536 - 18'(color[ch]))) * 57'(dval);
         s_in[ch] = SCALE_W'({color[ch], 8'h00}) + prod_s[ch][56:16];
         prod_m[ch] = 59'(pix_ff[ch]) * 59'(s_ff[ch]);
         lanes_in[ch].div = s_ff[ch];
         lanes_in[ch].rem = SCALE_W'({pix_ff[ch], 6'b0});
         // The divider leaves the quotient alone when density is not positive.
         if (cfg.div_en) begin
            lanes_in[ch].quo = '0;
         end else if (prod_m[ch][58:24] > 35'(SAMPLE_MAX)) begin
            lanes_in[ch].quo = SAMPLE_MAX;
         end else begin
            lanes_in[ch].quo = prod_m[ch][SAMPLE_W+23:24];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s_ff     <= s_in;
         pix_ff   <= in_pixel;
         lanes_ff <= lanes_in;
      end
   end

   assign out_valid = v2_ff;
   assign lanes     = lanes_ff;

   assert property (@(posedge clock) disable iff (reset)
      v1_ff |-> (s_ff[CHANNELS-1] >= SCALE_W'(Q24_ONE)))
      else $error("scale below one");

endmodule

@@ rtl/core/gdpf_divider.sv @@
// ----------------------------------------------------------------------------
// gdpf_divider
// Restoring divider, one quotient bit per stage for all four channels.
// The start remainder is the sample's upper dividend bits, which is already
// below the divisor, so only the eighteen quotient bits need stages.
// ----------------------------------------------------------------------------
module gdpf_divider import gdpf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  logic      div_en,
   input  logic      in_valid,
   input  lanes_type in_lanes,
   output logic      out_valid,
   output pixel_type quotient
);

   logic [DIV_STAGES-1:0]      v_ff;
   lanes_type [DIV_STAGES-1:0] st_ff;
   lanes_type [DIV_STAGES-1:0] st_in;

   always_comb begin
      logic [SCALE_W:0] shifted;
      logic             ge;
      for (int k = 0; k < DIV_STAGES; k++) begin
         for (int ch = 0; ch < CHANNELS; ch++) begin
            lane_type src;
            src = (k == 0) ? in_lanes[ch] : st_ff[(k == 0) ? 0 : k-1][ch];
            shifted = {src.rem, 1'b0};
            ge = shifted >= {1'b0, src.div};
            st_in[k][ch].div = src.div;
            st_in[k][ch].rem = ge ? SCALE_W'(shifted - {1'b0, src.div}) : src.rem << 1;
            st_in[k][ch].quo = div_en ? {src.quo[SAMPLE_W-2:0], ge} : src.quo;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= {v_ff[DIV_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st_ff <= st_in;
      end
   end

   always_comb begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
         quotient[ch] = st_ff[DIV_STAGES-1][ch].quo;
      end
   end

   assign out_valid = v_ff[DIV_STAGES-1];

   assert property (@(posedge clock) disable iff (reset)
      (v_ff[0] && div_en) |-> (st_ff[0][0].rem < st_ff[0][0].div))
      else $error("partial remainder not below divisor");
   assert property (@(posedge clock) disable iff (reset)
      (v_ff[DIV_STAGES-1] && div_en) |->
         (st_ff[DIV_STAGES-1][CHANNELS-1].rem < st_ff[DIV_STAGES-1][CHANNELS-1].div))
      else $error("final remainder not below divisor");

endmodule

@@ rtl/core/graduated_density_pixel_filter_unit.sv @@
// ----------------------------------------------------------------------------
// graduated_density_pixel_filter_unit
// Tinted graduated density filter for one four-channel pixel per transaction.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  req     | req_valid, req_stall, column/row/samples | in
//  rsp     | rsp_valid, rsp_stall, filtered samples   | out
//  csr     | csr_write_enable, csr_index, data        | in
//
// One pixel enters per cycle unless the pipe is stalled. Each pixel passes the
// position, exponential and scale sections and then the eighteen divider
// stages, one per quotient bit. Reset clears valid bits and loads register
// defaults. A stall on rsp with a result waiting freezes the whole pipe and
// raises req_stall in the same cycle; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module graduated_density_pixel_filter_unit import gdpf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [COORD_W-1:0]    req_column,
   input  logic [COORD_W-1:0]    req_row,
   input  logic [SAMPLE_W-1:0]   req_in_red,
   input  logic [SAMPLE_W-1:0]   req_in_green,
   input  logic [SAMPLE_W-1:0]   req_in_blue,
   input  logic [SAMPLE_W-1:0]   req_in_fourth,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [SAMPLE_W-1:0]   rsp_out_red,
   output logic [SAMPLE_W-1:0]   rsp_out_green,
   output logic [SAMPLE_W-1:0]   rsp_out_blue,
   output logic [SAMPLE_W-1:0]   rsp_out_fourth,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   logic [DENSITY_W-1:0]        density_ff;
   logic [TINTED-1:0][TINT_W-1:0] tint_ff;
   logic [POS_W-1:0]            origin_ff, col_step_ff, row_step_ff;
   cfg_type                     cfg;
   logic                        advance;
   pixel_type                   req_pixel, pos_pixel, exp_pixel, result;
   logic                        pos_valid, exp_valid, scale_valid;
   logic [X_W-1:0]              x;
   logic [D_W-1:0]              dval;
   lanes_type                   lanes;

   always_ff @(posedge clock) begin
      if (reset) begin
         density_ff  <= DENSITY_W'(512);
         tint_ff     <= {TINTED{TINT_W'(32768)}};
         origin_ff   <= '0;
         col_step_ff <= '0;
         row_step_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_DENSITY:    density_ff  <= csr_write_data[DENSITY_W-1:0];
            REG_TINT_RED:   tint_ff[0]  <= csr_write_data[TINT_W-1:0];
            REG_TINT_GREEN: tint_ff[1]  <= csr_write_data[TINT_W-1:0];
            REG_TINT_BLUE:  tint_ff[2]  <= csr_write_data[TINT_W-1:0];
            REG_ORIGIN:     origin_ff   <= csr_write_data;
            REG_COL_STEP:   col_step_ff <= csr_write_data;
            REG_ROW_STEP:   row_step_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Brightening inverts the tint colors; the fourth channel stays at zero.
   always_comb begin
      cfg.neg         = density_ff[DENSITY_W-1];
      cfg.div_en      = !density_ff[DENSITY_W-1] && (density_ff != '0);
      cfg.mag         = cfg.neg ? DENSITY_W'(~density_ff + DENSITY_W'(1)) : density_ff;
      for (int ch = 0; ch < TINTED; ch++) begin
         cfg.color[ch] = cfg.neg ? COLOR_W'(18'd65536 - 18'(tint_ff[ch]))
                                 : COLOR_W'(tint_ff[ch]);
      end
      cfg.origin      = $signed(origin_ff);
      cfg.column_step = $signed(col_step_ff);
      cfg.row_step    = $signed(row_step_ff);
   end

   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;
   assign req_pixel = {req_in_fourth, req_in_blue, req_in_green, req_in_red};

   gdpf_position u_position (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .column    (req_column),
      .row       (req_row),
      .in_pixel  (req_pixel),
      .out_valid (pos_valid),
      .x         (x),
      .out_pixel (pos_pixel)
   );

   gdpf_exp2 u_exp2 (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (pos_valid),
      .x         (x),
      .in_pixel  (pos_pixel),
      .out_valid (exp_valid),
      .dval      (dval),
      .out_pixel (exp_pixel)
   );

   gdpf_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .cfg       (cfg),
      .in_valid  (exp_valid),
      .dval      (dval),
      .in_pixel  (exp_pixel),
      .out_valid (scale_valid),
      .lanes     (lanes)
   );

   gdpf_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .div_en    (cfg.div_en),
      .in_valid  (scale_valid),
      .in_lanes  (lanes),
      .out_valid (rsp_valid),
      .quotient  (result)
   );

   assign rsp_out_red    = result[0];
   assign rsp_out_green  = result[1];
   assign rsp_out_blue   = result[2];
   assign rsp_out_fourth = result[3];

endmodule
